// File: rtl/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int VAL_W    = 32;
    localparam int PRI_W    = 16;
    localparam int ENTRY_W  = VAL_W + PRI_W;
    localparam int FILL_W   = 5;
    localparam int STATUS_W = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_CMP,
        ST_INS_HEAD,
        ST_RM_HEAD,
        ST_RM_SHIFT
    } state_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        WR_PORT,
        WR_HELD,
        WR_MOVE
    } wr_src_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef struct packed {
        logic    rd_en;
        logic    wr_en;
        wr_src_t wr_src;
        logic    head_take;
        logic    out_take;
        logic    done;
        status_t status;
    } ctl_t;

endpackage

`default_nettype wire

// File: rtl/spq_store.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_store #(
    parameter int DEPTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  wire logic [spq_pkg::ENTRY_W-1:0] wr_data,
    input  wire logic                       rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic      [spq_pkg::ENTRY_W-1:0] rd_data
);

    logic [spq_pkg::ENTRY_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/spq_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_ctrl #(
    parameter int CAPACITY = 16
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic                            operation,
    input  wire logic                            moves,
    output logic                                 busy,
    output logic                                 cmp_head,
    output spq_pkg::ctl_t                        ctl,
    output logic [$clog2(CAPACITY)-1:0]          rd_addr,
    output logic [$clog2(CAPACITY)-1:0]          wr_addr,
    output logic [$clog2(CAPACITY+1)-1:0]        count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    spq_pkg::state_t state_reg, state_next;
    logic [CW-1:0]   idx_reg, idx_next;
    logic [CW-1:0]   count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spq_pkg::ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
        end
    end

    // next state, walk index and fill count
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == spq_pkg::OP_REMOVE)
                    begin
                        if (count_reg != '0)
                        begin
                            state_next = spq_pkg::ST_RM_HEAD;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        count_next = count_reg + ONE_C;
                    end
                    else if (count_reg != CAP_C)
                    begin
                        idx_next   = count_reg;
                        state_next = spq_pkg::ST_INS_CMP;
                    end
                end
            end
            spq_pkg::ST_INS_CMP:
            begin
                if (moves)
                begin
                    if (idx_reg == ONE_C)
                    begin
                        state_next = spq_pkg::ST_INS_HEAD;
                    end
                    else
                    begin
                        idx_next = idx_reg - ONE_C;
                    end
                end
                else
                begin
                    count_next = count_reg + ONE_C;
                    state_next = spq_pkg::ST_IDLE;
                end
            end
            spq_pkg::ST_INS_HEAD:
            begin
                count_next = count_reg + ONE_C;
                state_next = spq_pkg::ST_IDLE;
            end
            spq_pkg::ST_RM_HEAD:
            begin
                if (count_reg == ONE_C)
                begin
                    count_next = count_reg - ONE_C;
                    state_next = spq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next   = ONE_C;
                    state_next = spq_pkg::ST_RM_SHIFT;
                end
            end
            spq_pkg::ST_RM_SHIFT:
            begin
                if (idx_reg == count_reg - ONE_C)
                begin
                    count_next = count_reg - ONE_C;
                    state_next = spq_pkg::ST_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + ONE_C;
                end
            end
            default:
            begin
                state_next = spq_pkg::ST_IDLE;
            end
        endcase
    end

    // memory port controls and result flags
    always_comb
    begin
        ctl     = '0;
        rd_addr = '0;
        wr_addr = '0;
        unique case (state_reg)
            spq_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (operation == spq_pkg::OP_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            ctl.done   = 1'b1;
                            ctl.status = spq_pkg::STATUS_EMPTY;
                        end
                        else
                        begin
                            ctl.rd_en = 1'b1;
                        end
                    end
                    else if (count_reg == CAP_C)
                    begin
                        ctl.done   = 1'b1;
                        ctl.status = spq_pkg::STATUS_FULL;
                    end
                    else if (count_reg == '0)
                    begin
                        ctl.wr_en  = 1'b1;
                        ctl.wr_src = spq_pkg::WR_PORT;
                        ctl.done   = 1'b1;
                    end
                    else
                    begin
                        // start the walk at the tail
                        ctl.rd_en = 1'b1;
                        rd_addr   = AW'(count_reg - ONE_C);
                    end
                end
            end
            spq_pkg::ST_INS_CMP:
            begin
                wr_addr      = AW'(idx_reg);
                ctl.wr_en    = 1'b1;
                if (moves)
                begin
                    ctl.wr_src = spq_pkg::WR_MOVE;
                    if (idx_reg != ONE_C)
                    begin
                        ctl.rd_en = 1'b1;
                        rd_addr   = AW'(idx_reg - CW'(2));
                    end
                end
                else
                begin
                    ctl.wr_src = spq_pkg::WR_HELD;
                    ctl.done   = 1'b1;
                end
            end
            spq_pkg::ST_INS_HEAD:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_src = spq_pkg::WR_HELD;
                ctl.done   = 1'b1;
            end
            spq_pkg::ST_RM_HEAD:
            begin
                ctl.head_take = 1'b1;
                if (count_reg == ONE_C)
                begin
                    ctl.done     = 1'b1;
                    ctl.out_take = 1'b1;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = AW'(1);
                end
            end
            spq_pkg::ST_RM_SHIFT:
            begin
                ctl.wr_en  = 1'b1;
                ctl.wr_src = spq_pkg::WR_MOVE;
                wr_addr    = AW'(idx_reg - ONE_C);
                if (idx_reg == count_reg - ONE_C)
                begin
                    ctl.done     = 1'b1;
                    ctl.out_take = 1'b1;
                end
                else
                begin
                    ctl.rd_en = 1'b1;
                    rd_addr   = AW'(idx_reg + ONE_C);
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    assign busy     = (state_reg != spq_pkg::ST_IDLE);
    assign cmp_head = (state_reg == spq_pkg::ST_INS_CMP) && (idx_reg == ONE_C);
    assign count    = count_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("fill count above capacity");

    a_port_clash: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.rd_en && ctl.wr_en && busy |-> rd_addr != wr_addr)
        else $error("read and write hit the same entry");

    a_ins_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::ST_INS_CMP |-> idx_reg != '0 && idx_reg <= count_reg)
        else $error("insert walk index out of range");

    a_rm_idx: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == spq_pkg::ST_RM_SHIFT |-> idx_reg != '0 && idx_reg < count_reg)
        else $error("remove walk index out of range");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.done |=> state_reg == spq_pkg::ST_IDLE)
        else $error("sequencer busy after finishing a transfer");

endmodule

`default_nettype wire

// File: rtl/sorted_priority_queue.sv
// Insert: finishes in the accept cycle into an empty or full queue, else entries move back.
// Remove: finishes in the accept cycle on an empty queue, else the held entries shift forward.
// Busy is high past the accept cycle; done shows in the cycle after the operation finishes.
// One store with a read and a write port plus one priority subtractor, one item in flight.
// Reset clears the fill count, sequencer and done strobe; the store is never cleared.
// The receiver cannot stall: each result shows for exactly one cycle with done.
`timescale 1ns / 1ps
`default_nettype none

module sorted_priority_queue #(
    parameter int CAPACITY = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          operation,
    input  wire logic signed [spq_pkg::VAL_W-1:0] entry_value,
    input  wire logic signed [spq_pkg::PRI_W-1:0] entry_priority,
    output logic                               done,
    output logic signed [spq_pkg::VAL_W-1:0]   out_value,
    output logic signed [spq_pkg::PRI_W-1:0]   out_priority,
    output logic        [spq_pkg::STATUS_W-1:0] status,
    output logic        [spq_pkg::FILL_W-1:0]  fill_count
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    spq_pkg::ctl_t               ctl;
    logic                        cmp_head;
    logic [AW-1:0]               rd_addr;
    logic [AW-1:0]               wr_addr;
    logic [CW-1:0]               count;
    logic                        moves;
    logic [spq_pkg::ENTRY_W-1:0] rd_data;
    logic [spq_pkg::ENTRY_W-1:0] wr_data;
    logic [spq_pkg::VAL_W-1:0]   rd_val;
    logic [spq_pkg::PRI_W-1:0]   rd_pri;
    logic [spq_pkg::PRI_W:0]     pri_diff;

    logic [spq_pkg::VAL_W-1:0]   held_val_reg;
    logic [spq_pkg::PRI_W-1:0]   held_pri_reg;
    logic [spq_pkg::VAL_W-1:0]   head_val_reg;
    logic [spq_pkg::PRI_W-1:0]   head_pri_reg;
    logic                        done_reg;
    logic [spq_pkg::VAL_W-1:0]   out_val_reg;
    logic [spq_pkg::PRI_W-1:0]   out_pri_reg;
    spq_pkg::status_t            status_reg;

    spq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .moves     (moves),
        .busy      (busy),
        .cmp_head  (cmp_head),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .wr_addr   (wr_addr),
        .count     (count)
    );

    spq_store #(
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctl.wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (ctl.rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_pri = rd_data[spq_pkg::ENTRY_W-1:spq_pkg::VAL_W];
    assign rd_val = rd_data[spq_pkg::VAL_W-1:0];

    // one subtractor serves both tests: strictly above at the head, at least elsewhere
    assign pri_diff = {rd_pri[spq_pkg::PRI_W-1], rd_pri}
                    - {held_pri_reg[spq_pkg::PRI_W-1], held_pri_reg};
    assign moves = cmp_head ? (!pri_diff[spq_pkg::PRI_W] && (pri_diff != '0))
                            : !pri_diff[spq_pkg::PRI_W];

    always_comb
    begin
        case (ctl.wr_src)
            spq_pkg::WR_PORT: wr_data = {entry_priority, entry_value};
            spq_pkg::WR_HELD: wr_data = {held_pri_reg, held_val_reg};
            spq_pkg::WR_MOVE: wr_data = rd_data;
            default:          wr_data = rd_data;
        endcase
    end

    // hold the new entry for the walk and the head taken on a remove
    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            held_val_reg <= entry_value;
            held_pri_reg <= entry_priority;
        end
        if (ctl.head_take)
        begin
            head_val_reg <= rd_val;
            head_pri_reg <= rd_pri;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= ctl.done;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.done)
        begin
            status_reg <= ctl.status;
            if (ctl.out_take)
            begin
                out_val_reg <= ctl.head_take ? rd_val : head_val_reg;
                out_pri_reg <= ctl.head_take ? rd_pri : head_pri_reg;
            end
            else
            begin
                out_val_reg <= '0;
                out_pri_reg <= '0;
            end
        end
    end

    assign done         = done_reg;
    assign out_value    = out_val_reg;
    assign out_priority = out_pri_reg;
    assign status       = status_reg;
    assign fill_count   = spq_pkg::FILL_W'(count);

endmodule

`default_nettype wire
